// File: hw/rtl/tcd_pkg.sv
// Shared constants, types and the month length table for the tick count to
// calendar date block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcd_pkg;

   // Field widths
   localparam int TICK_W   = 64;
   localparam int CSR_W    = 32;
   localparam int DAYS_W   = 48;
   localparam int YEAR_O_W = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int RSP_W    = YEAR_O_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;

   // Calendar constants
   localparam int MAX_YEAR      = 9999;
   localparam int EPOCH_YEAR    = 1970;
   localparam int SECS_PER_MIN  = 60;
   localparam int MINS_PER_HOUR = 60;
   localparam int HOURS_PER_DAY = 24;
   localparam int YEAR_W = ($clog2(MAX_YEAR + 2) > YEAR_O_W) ?
                           $clog2(MAX_YEAR + 2) : YEAR_O_W;

   localparam logic [CSR_W-1:0] RESET_FREQ = 32'd10000000;

   // Register map: the index is the word address bit
   localparam logic REG_TICK_FREQUENCY = 1'b0;
   localparam logic REG_EPOCH_OFFSET   = 1'b1;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic done;
      logic overflow;
   } walk_status_type;

   // Days in a month, February extended in leap years
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tick_count_to_calendar_date.sv
// Top level of the tick count to calendar date converter: register port,
// sequencer, output register. Depends on tcd_pkg, tcd_serial_div and
// tcd_calendar_walk.
//
// Usage
//   req_*  : one transfer carries a 64-bit timer tick count in req_tdata.
//   rsp_*  : one transfer per request carries the calendar date in rsp_tdata
//            and the year overflow flag in rsp_tuser.
//   csr_*  : APB-style port, tick_frequency at 0x0, epoch_offset at 0x4.
//            Write registers only while no request is in flight.
// Sequence
//   Four passes of the shared bit-serial divider (ticks / frequency, then
//   / 60, / 60, / 24) are followed by the calendar walk, which steps one
//   year at a time from 1970 and then one month at a time.
// Throughput
//   One request at a time; req_tready is high while the sequencer is idle.
//   A finished result waits in the output register, so the next request is
//   accepted while the receiver stalls; its result waits until that register
//   is free.
// Reset
//   Synchronous, active high: registers return to their defaults, the
//   sequencer goes idle and any held result is dropped.
`timescale 1ns / 1ps
`default_nettype none

module tick_count_to_calendar_date
   import tcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request: tick_count [63:0]
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [TICK_W-1:0] req_tdata,
   // result: year [13:0], month [17:14], day [22:18], hour [27:23],
   //         minute [33:28], second [39:34]
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,
   // result: year_overflow [0]
   output logic                   rsp_tuser,
   // register port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]       csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_TICK,
      S_DIV_SEC,
      S_DIV_MIN,
      S_DIV_HOUR,
      S_WALK,
      S_FINISH
   } seq_state_type;

   localparam logic [YEAR_O_W-1:0] SAT_YEAR = YEAR_O_W'(MAX_YEAR);

   // Configuration registers
   logic [CSR_W-1:0] freq_ff;
   logic [CSR_W-1:0] epoch_ff;
   logic             csr_write;

   // Sequencer
   seq_state_type     state_ff;
   logic              div_start_ff;
   logic              walk_start_ff;
   logic [TICK_W-1:0] operand_ff;
   logic [CSR_W-1:0]  divisor_ff;
   logic [SEC_W-1:0]  second_ff;
   logic [MIN_W-1:0]  minute_ff;
   logic [HOUR_W-1:0] hour_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic              rsp_user_ff;

   // Divider and walk connections
   logic              div_done;
   logic [TICK_W-1:0] div_quo;
   logic [CSR_W-1:0]  div_rem;
   walk_status_type   walk_status;
   logic [YEAR_W-1:0] walk_year;
   logic [MONTH_W-1:0] walk_month;
   logic [DAY_W-1:0]  walk_day;

   logic [TICK_W:0]   sum_wide;
   logic [TICK_W-1:0] unix_secs;
   logic              rsp_free;

   // ---------------------------------------------------------------
   // Register port: write on the access cycle, reads are combinational
   // ---------------------------------------------------------------
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_EPOCH_OFFSET) ? epoch_ff : freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= RESET_FREQ;
         epoch_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_TICK_FREQUENCY: freq_ff  <= csr_pwdata;
            REG_EPOCH_OFFSET:   epoch_ff <= csr_pwdata;
            default:            freq_ff  <= freq_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Shared serial divider and calendar walk
   // ---------------------------------------------------------------
   tcd_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (operand_ff),
      .divisor   (divisor_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   tcd_calendar_walk u_walk (
      .clock  (clock),
      .reset  (reset),
      .start  (walk_start_ff),
      .days   (operand_ff[DAYS_W-1:0]),
      .status (walk_status),
      .year   (walk_year),
      .month  (walk_month),
      .day    (walk_day)
   );

   // Elapsed seconds plus epoch offset, held at all ones on carry out
   always_comb begin
      sum_wide  = {1'b0, div_quo} + {{(TICK_W-CSR_W+1){1'b0}}, epoch_ff};
      unix_secs = sum_wide[TICK_W] ? '1 : sum_wide[TICK_W-1:0];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------
   // Sequencer: divide ticks, split seconds, minutes and hours, walk
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         div_start_ff  <= 1'b0;
         walk_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         div_start_ff  <= 1'b0;
         walk_start_ff <= 1'b0;
         // load a finished result, else drop the one just taken
         if ((state_ff == S_FINISH) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  // a zero frequency divides by one
                  operand_ff   <= req_tdata;
                  divisor_ff   <= (freq_ff == '0) ? CSR_W'(1) : freq_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_TICK;
               end
            end
            S_DIV_TICK: begin
               if (div_done) begin
                  operand_ff   <= unix_secs;
                  divisor_ff   <= CSR_W'(SECS_PER_MIN);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_SEC;
               end
            end
            S_DIV_SEC: begin
               if (div_done) begin
                  second_ff    <= div_rem[SEC_W-1:0];
                  operand_ff   <= div_quo;
                  divisor_ff   <= CSR_W'(MINS_PER_HOUR);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_MIN;
               end
            end
            S_DIV_MIN: begin
               if (div_done) begin
                  minute_ff    <= div_rem[MIN_W-1:0];
                  operand_ff   <= div_quo;
                  divisor_ff   <= CSR_W'(HOURS_PER_DAY);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_HOUR;
               end
            end
            S_DIV_HOUR: begin
               if (div_done) begin
                  // whole days stay in the operand register for the walk
                  hour_ff       <= div_rem[HOUR_W-1:0];
                  operand_ff    <= div_quo;
                  walk_start_ff <= 1'b1;
                  state_ff      <= S_WALK;
               end
            end
            S_WALK: begin
               if (walk_status.done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // hold until the output register is free
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Result payload, saturated past the last year
   always_ff @(posedge clock) begin
      if ((state_ff == S_FINISH) && rsp_free) begin
         if (walk_status.overflow) begin
            rsp_data_ff <= {6'd59, 6'd59, 5'd23, 5'd31, MONTH_DEC, SAT_YEAR};
         end else begin
            rsp_data_ff <= {second_ff, minute_ff, hour_ff, walk_day, walk_month,
                            walk_year[YEAR_O_W-1:0]};
         end
         rsp_user_ff <= walk_status.overflow;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_TICK) || (state_ff == S_DIV_SEC) ||
                   (state_ff == S_DIV_MIN) || (state_ff == S_DIV_HOUR))
      else $error("divider finished outside a divide step");

   a_walk_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_status.done |-> (state_ff == S_WALK))
      else $error("calendar walk finished outside the walk step");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:14] >= MONTH_JAN) && (rsp_tdata[17:14] <= MONTH_DEC))
      else $error("result month out of range");

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[YEAR_O_W-1:0] == SAT_YEAR))
      else $error("overflow result without saturated year");

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> div_start_ff && (state_ff == S_DIV_TICK))
      else $error("accepted request did not start the divider");

endmodule

`default_nettype wire

// File: hw/rtl/tcd_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tcd_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module tcd_serial_div
   import tcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TICK_W-1:0] dividend,
   input  wire logic [CSR_W-1:0]  divisor,
   output logic                   done,
   output logic [TICK_W-1:0]      quotient,
   output logic [CSR_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(TICK_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TICK_W-1:0] quo_ff, quo_in;
   logic [CSR_W-1:0]  rem_ff, rem_in;
   logic [CSR_W-1:0]  dsr_ff, dsr_in;
   logic [CSR_W:0]    trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[TICK_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         quo_in = {quo_ff[TICK_W-2:0], fits};
         rem_in = fits ? CSR_W'(trial - {1'b0, dsr_ff}) : trial[CSR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tcd_calendar_walk.sv
// Year and month walk: one year or one month per cycle from the epoch year.
// Depends on tcd_pkg for the calendar constants and the month table.
`timescale 1ns / 1ps
`default_nettype none

module tcd_calendar_walk
   import tcd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DAYS_W-1:0]  days,
   output walk_status_type         status,
   output logic [YEAR_W-1:0]       year,
   output logic [MONTH_W-1:0]      month,
   output logic [DAY_W-1:0]        day
);

   typedef enum logic [1:0] {
      W_IDLE,
      W_YEAR,
      W_MONTH
   } walk_state_type;

   localparam logic [1:0] M4_INIT   = 2'(EPOCH_YEAR % 4);
   localparam logic [6:0] M100_INIT = 7'(EPOCH_YEAR % 100);
   localparam logic [8:0] M400_INIT = 9'(EPOCH_YEAR % 400);

   walk_state_type     state_ff;
   logic [DAYS_W-1:0]  days_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [1:0]         m4_ff;
   logic [6:0]         m100_ff;
   logic [8:0]         m400_ff;
   logic               done_ff;
   logic               over_ff;

   logic               leap;
   logic [8:0]         year_len;
   logic [DAY_W-1:0]   mon_len;
   logic [8:0]         days_short;

   always_comb begin
      leap       = ((m4_ff == 2'd0) && (m100_ff != 7'd0)) || (m400_ff == 9'd0);
      year_len   = leap ? 9'd366 : 9'd365;
      mon_len    = month_days(month_ff, leap);
      days_short = days_ff[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            W_IDLE: begin
               if (start) begin
                  state_ff <= W_YEAR;
                  days_ff  <= days;
                  year_ff  <= YEAR_W'(EPOCH_YEAR);
                  month_ff <= MONTH_JAN;
                  m4_ff    <= M4_INIT;
                  m100_ff  <= M100_INIT;
                  m400_ff  <= M400_INIT;
                  over_ff  <= 1'b0;
               end
            end
            W_YEAR: begin
               if (year_ff > YEAR_W'(MAX_YEAR)) begin
                  over_ff  <= 1'b1;
                  done_ff  <= 1'b1;
                  state_ff <= W_IDLE;
               end else if (days_ff < {{(DAYS_W-9){1'b0}}, year_len}) begin
                  state_ff <= W_MONTH;
               end else begin
                  // drop one whole year and advance the leap counters
                  days_ff <= days_ff - {{(DAYS_W-9){1'b0}}, year_len};
                  year_ff <= year_ff + 1'b1;
                  m4_ff   <= m4_ff + 1'b1;
                  m100_ff <= (m100_ff == 7'd99) ? 7'd0 : m100_ff + 1'b1;
                  m400_ff <= (m400_ff == 9'd399) ? 9'd0 : m400_ff + 1'b1;
               end
            end
            W_MONTH: begin
               if ((month_ff != MONTH_DEC) && (days_short >= {4'd0, mon_len})) begin
                  days_ff  <= days_ff - {{(DAYS_W-DAY_W){1'b0}}, mon_len};
                  month_ff <= month_ff + 1'b1;
               end else begin
                  done_ff  <= 1'b1;
                  state_ff <= W_IDLE;
               end
            end
            default: state_ff <= W_IDLE;
         endcase
      end
   end

   assign status.done     = done_ff;
   assign status.overflow = over_ff;
   assign year            = year_ff;
   assign month           = month_ff;
   assign day             = DAY_W'(days_short + 9'd1);

endmodule

`default_nettype wire
